[sv/baro_pkg.sv]
// Package for the barometer second-order compensation unit.
// Holds shared widths, register indexes and the multiplier control struct.
// No dependencies.
package baro_pkg;

    localparam int CoefW = 16;
    localparam int RawW  = 24;
    localparam int AccW  = 72;

    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    localparam logic signed [AccW-1:0] TempRef  = AccW'(2000);
    localparam logic signed [AccW-1:0] TempCold = -AccW'(1500);
    localparam logic [RawW-1:0] RawTempInit = 24'd8000000;
    localparam logic signed [AccW-1:0] PressMin = AccW'(1000);
    localparam logic signed [AccW-1:0] PressMax = AccW'(150000);

    // Start request and operands for the serial multiplier.
    typedef struct packed {
        logic                   start;
        logic signed [AccW-1:0] a;
        logic signed [AccW-1:0] b;
    } mul_req_t;

endpackage

[sv/baro_second_order_compensation_unit.sv]
// Top level of the barometer second-order compensation unit.
// Depends on baro_pkg and baro_serial_mul.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, kind, raw_value
//  out     | output    | out_valid, out_stall, temp_centideg, press_centimbar, plausible
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// A temperature transaction updates the cache and sets the seen flag. A pressure
// transaction runs four, six or seven products through one bit-serial multiplier; each
// product stops after the highest set bit of its multiplier operand, and the ST_OUT
// step then loads the output register. Reset clears the coefficients, the cache to
// 8000000 and the seen flag. One result is held in the output register until taken;
// the next input transaction is accepted meanwhile, and a finished pressure
// transaction waits while that result stalls.
module baro_second_order_compensation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [baro_pkg::RawW-1:0]     raw_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [19:0]            temp_centideg,
    output logic signed [31:0]            press_centimbar,
    output logic                          plausible,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [baro_pkg::CoefW-1:0]    cfg_data
);
    import baro_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_DT6   = 9'b0_0000_0010,
        ST_C4    = 9'b0_0000_0100,
        ST_C3    = 9'b0_0000_1000,
        ST_DTSQ  = 9'b0_0001_0000,
        ST_SQ    = 9'b0_0010_0000,
        ST_SC    = 9'b0_0100_0000,
        ST_D     = 9'b0_1000_0000,
        ST_OUT   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CoefW-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic [RawW-1:0] cache_reg, cache_next;
    logic seen_reg, seen_next;
    logic [RawW-1:0] praw_reg, praw_next;
    logic signed [AccW-1:0] dt_reg, dt_next, temp_reg, temp_next;
    logic signed [AccW-1:0] off_reg, off_next, sens_reg, sens_next;
    logic signed [AccW-1:0] t1_reg, t1_next;
    logic cold_reg, cold_next;
    logic ov_reg, ov_next;
    logic signed [19:0] ot_reg, ot_next;
    logic signed [31:0] op_reg, op_next;
    logic opl_reg, opl_next;

    mul_req_t req;
    logic mul_done;
    logic signed [AccW-1:0] prod;
    logic signed [AccW-1:0] p_full, sq_diff, sc_diff;
    logic in_acc;

    baro_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .done    (mul_done),
        .product (prod)
    );

    // Busy while computing, or while an older result would be overwritten.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign p_full   = ((prod >>> 21) - off_reg) >>> 15;
    assign sq_diff  = temp_reg - TempRef;
    assign sc_diff  = temp_reg - TempCold;

    // Sequencer over the products; every product step waits for the multiplier.
    always_comb
    begin
        state_next = state_reg;
        cache_next = cache_reg;
        seen_next  = seen_reg;
        praw_next  = praw_reg;
        dt_next    = dt_reg;
        temp_next  = temp_reg;
        off_next   = off_reg;
        sens_next  = sens_reg;
        t1_next    = t1_reg;
        cold_next  = cold_reg;
        ov_next    = ov_reg;
        ot_next    = ot_reg;
        op_next    = op_reg;
        opl_next   = opl_reg;
        req        = '{start: 1'b0, a: '0, b: '0};
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind)
                    begin
                        cache_next = raw_value;
                        seen_next  = 1'b1;
                    end
                    else if (seen_reg)
                    begin
                        praw_next  = raw_value;
                        dt_next    = AccW'(cache_reg) - (AccW'(c5_reg) <<< 8);
                        req.start  = 1'b1;
                        req.a      = AccW'(cache_reg) - (AccW'(c5_reg) <<< 8);
                        req.b      = AccW'(c6_reg);
                        state_next = ST_DT6;
                    end
                end
            end
            ST_DT6:
            begin
                if (mul_done)
                begin
                    temp_next  = TempRef + (prod >>> 23);
                    req.start  = 1'b1;
                    req.a      = dt_reg;
                    req.b      = AccW'(c4_reg);
                    state_next = ST_C4;
                end
            end
            ST_C4:
            begin
                if (mul_done)
                begin
                    off_next   = $signed(AccW'(c2_reg) <<< 16) + (prod >>> 7);
                    req.start  = 1'b1;
                    req.a      = dt_reg;
                    req.b      = AccW'(c3_reg);
                    state_next = ST_C3;
                end
            end
            ST_C3:
            begin
                if (mul_done)
                begin
                    sens_next = $signed(AccW'(c1_reg) <<< 15) + (prod >>> 8);
                    req.start = 1'b1;
                    if (temp_reg < TempRef)
                    begin
                        req.a      = dt_reg;
                        req.b      = dt_reg;
                        state_next = ST_DTSQ;
                    end
                    else
                    begin
                        req.a      = AccW'(praw_reg);
                        req.b      = $signed(AccW'(c1_reg) <<< 15) + (prod >>> 8);
                        state_next = ST_D;
                    end
                end
            end
            ST_DTSQ:
            begin
                if (mul_done)
                begin
                    t1_next    = prod >>> 31;
                    cold_next  = temp_reg < TempCold;
                    req.start  = 1'b1;
                    req.a      = sq_diff;
                    req.b      = sq_diff;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mul_done)
                begin
                    // Five times the square: (sq << 2) + sq.
                    off_next  = off_reg - (((prod <<< 2) + prod) >>> 1);
                    sens_next = sens_reg - (((prod <<< 2) + prod) >>> 2);
                    req.start = 1'b1;
                    if (cold_reg)
                    begin
                        req.a      = sc_diff;
                        req.b      = sc_diff;
                        state_next = ST_SC;
                    end
                    else
                    begin
                        temp_next  = temp_reg - t1_reg;
                        req.a      = AccW'(praw_reg);
                        req.b      = sens_reg - (((prod <<< 2) + prod) >>> 2);
                        state_next = ST_D;
                    end
                end
            end
            ST_SC:
            begin
                if (mul_done)
                begin
                    off_next   = off_reg - ((prod <<< 3) - prod);
                    sens_next  = sens_reg - (((prod <<< 3) + (prod <<< 1) + prod) >>> 1);
                    temp_next  = temp_reg - t1_reg;
                    req.start  = 1'b1;
                    req.a      = AccW'(praw_reg);
                    req.b      = sens_reg - (((prod <<< 3) + (prod <<< 1) + prod) >>> 1);
                    state_next = ST_D;
                end
            end
            ST_D:
            begin
                if (mul_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait here until the output register is free; the product holds.
                if (!ov_next)
                begin
                    ot_next = temp_reg[19:0];
                    if (p_full > AccW'(32'sh7FFF_FFFF))
                    begin
                        op_next = 32'sh7FFF_FFFF;
                    end
                    else if (p_full < -AccW'(64'sh8000_0000))
                    begin
                        op_next = 32'sh8000_0000;
                    end
                    else
                    begin
                        op_next = p_full[31:0];
                    end
                    opl_next   = (p_full >= PressMin) && (p_full <= PressMax);
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cache_reg <= RawTempInit;
            seen_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
            c5_reg    <= '0;
            c6_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cache_reg <= cache_next;
            seen_reg  <= seen_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_C1: c1_reg <= cfg_data;
                    REG_C2: c2_reg <= cfg_data;
                    REG_C3: c3_reg <= cfg_data;
                    REG_C4: c4_reg <= cfg_data;
                    REG_C5: c5_reg <= cfg_data;
                    REG_C6: c6_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        praw_reg <= praw_next;
        dt_reg   <= dt_next;
        temp_reg <= temp_next;
        off_reg  <= off_next;
        sens_reg <= sens_next;
        t1_reg   <= t1_next;
        cold_reg <= cold_next;
        ot_reg   <= ot_next;
        op_reg   <= op_next;
        opl_reg  <= opl_next;
    end

    assign out_valid       = ov_reg;
    assign temp_centideg   = ot_reg;
    assign press_centimbar = op_reg;
    assign plausible       = opl_reg;

    // The multiplier only finishes while a pressure transaction is running.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg != ST_IDLE))
        else $error("multiplier finished while idle");

    // A new result appears only when leaving the output step.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result without final product");

    // A temperature transaction marks the cache as seen.
    a_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind) |=> seen_reg)
        else $error("seen flag not set");
endmodule

[sv/baro_serial_mul.sv]
// Bit-serial signed multiplier: one bit of the multiplier operand a cycle.
// Depends on baro_pkg.
module baro_serial_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  baro_pkg::mul_req_t              req,
    output logic                            done,
    output logic signed [baro_pkg::AccW-1:0] product
);
    import baro_pkg::*;

    localparam int CntW = $clog2(AccW + 1);

    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [AccW-1:0] mcand_reg, mcand_next;
    logic [AccW-1:0] mplier_reg, mplier_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    // Shift-and-add over the multiplier bits, two's complement modulo 2^AccW.
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = req.a;
            mplier_next = req.b;
            cnt_next    = CntW'(AccW);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1) || mplier_next == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

[dv/baro_compensation_checker.sv]
// Checker for the barometer compensation unit: watches the input, output and
// configuration ports, predicts each compensated result and compares it.
// Depends on baro_pkg.
module baro_compensation_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       kind,
    input  logic [baro_pkg::RawW-1:0]  raw_value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [19:0]         temp_centideg,
    input  logic signed [31:0]         press_centimbar,
    input  logic                       plausible,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [baro_pkg::CoefW-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import baro_pkg::*;

    typedef struct packed {
        logic signed [19:0] temp;
        logic signed [31:0] press;
        logic               ok;
    } reading_t;

    reading_t                  readings_due[$];
    logic [CoefW-1:0]          cal_word [6];
    logic [RawW-1:0]           cached_temp;
    logic                      have_temp;

    assign pending_count = readings_due.size();

    // Floor division by a power of two; >>> on a signed longint rounds down.
    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic reading_t compensate(logic [RawW-1:0] raw);
        longint dt, t, off, sens, p, t2, sq, off2, sens2, sc;
        reading_t r;
        dt   = longint'(cached_temp) - longint'(cal_word[REG_C5]) * 256;
        t    = 2000 + fshift(dt * longint'(cal_word[REG_C6]), 23);
        off  = longint'(cal_word[REG_C2]) * 65536
             + fshift(longint'(cal_word[REG_C4]) * dt, 7);
        sens = longint'(cal_word[REG_C1]) * 32768
             + fshift(longint'(cal_word[REG_C3]) * dt, 8);
        // Second-order correction below 20 C, extra term below -15 C.
        if (t < 2000)
        begin
            t2    = fshift(dt * dt, 31);
            sq    = (t - 2000) * (t - 2000);
            off2  = fshift(5 * sq, 1);
            sens2 = fshift(5 * sq, 2);
            if (t < -1500)
            begin
                sc    = (t + 1500) * (t + 1500);
                off2  = off2 + 7 * sc;
                sens2 = sens2 + fshift(11 * sc, 1);
            end
            t    = t - t2;
            off  = off - off2;
            sens = sens - sens2;
        end
        p = fshift(fshift(longint'(raw) * sens, 21) - off, 15);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        r.temp  = t[19:0];
        r.press = p[31:0];
        r.ok    = (p >= 1000 && p <= 150000);
        return r;
    endfunction

    // Track configuration and input transactions, then check results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                cal_word[i] <= '0;
            cached_temp <= RawTempInit;
            have_temp   <= 1'b0;
            fail_count  <= 0;
            readings_due.delete();
        end
        else
        begin
            if (cfg_we && cfg_index < 6)
                cal_word[cfg_index] <= cfg_data;
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected result temp=%0d press=%0d plausible=%0b",
                             $time, temp_centideg, press_centimbar, plausible);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    reading_t e;
                    e = readings_due.pop_front();
                    if (e.temp !== temp_centideg || e.press !== press_centimbar
                        || e.ok !== plausible)
                    begin
                        $display("%0t: mismatch expected temp=%0d press=%0d plausible=%0b",
                                 $time, e.temp, e.press, e.ok);
                        $display("%0t:          actual   temp=%0d press=%0d plausible=%0b",
                                 $time, temp_centideg, press_centimbar, plausible);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind)
                begin
                    cached_temp <= raw_value;
                    have_temp   <= 1'b1;
                end
                else if (have_temp)
                    readings_due.push_back(compensate(raw_value));
            end
        end
    end
endmodule

[dv/baro_second_order_compensation_unit_test.sv]
// Testbench top for the barometer compensation unit: drives conversions and
// calibration words, randomizes idling, and gives the verdict.
// Depends on baro_pkg, the unit and baro_compensation_checker.
module baro_second_order_compensation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import baro_pkg::*;

    logic clk = 1'b0, rst_n = 1'b0;
    logic in_valid = 1'b0, in_stall, kind = 1'b0, out_valid, out_stall = 1'b0;
    logic [RawW-1:0] raw_value = '0;
    logic signed [19:0] temp_centideg;
    logic signed [31:0] press_centimbar;
    logic plausible, cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_C1;
    logic [CoefW-1:0] cfg_data = '0;
    int fail_count, pending_count;
    bit quiet_tail = 0;
    bit hold_off = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    baro_second_order_compensation_unit dut (.*);
    baro_compensation_checker checker_i (.*);

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one conversion and hold it until the block takes it.
    task automatic send_conversion(logic k, logic [RawW-1:0] v);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        raw_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write all calibration words; only called while the block is idle.
    task automatic load_calibration(logic [CoefW-1:0] w [6]);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= w[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [RawW-1:0] rand_raw();
        case ($urandom_range(0, 3))
            0: return RawW'($urandom);
            1: return RawW'($urandom_range(7000000, 9500000));
            2: return '1;
            default: return RawW'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [CoefW-1:0] w [6];
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients; pressure before any temperature yields nothing.
        send_conversion(1'b0, 24'd1234567);
        send_conversion(1'b1, 24'd8000000);
        send_conversion(1'b0, 24'd9000000);

        // Typical datasheet-like calibration, then field extremes.
        w = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        load_calibration(w);
        send_conversion(1'b1, 24'd8077636);
        send_conversion(1'b0, 24'd6465444);
        send_conversion(1'b1, 24'd0);         // very cold, both extra terms
        send_conversion(1'b0, 24'hFFFFFF);
        send_conversion(1'b0, 24'd0);
        send_conversion(1'b1, 24'hFFFFFF);    // hot, first order only
        send_conversion(1'b0, 24'hFFFFFF);
        send_conversion(1'b0, 24'd1);
        send_conversion(1'b1, 24'd7500000);   // cold, just below -15 C, both extra terms
        send_conversion(1'b0, 24'd8500000);

        // Extreme calibration words, all-ones or zero.
        w = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        load_calibration(w);
        send_conversion(1'b1, 24'hFFFFFF);
        send_conversion(1'b0, 24'hFFFFFF);
        w = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_calibration(w);
        send_conversion(1'b1, 24'd0);
        send_conversion(1'b0, 24'hFFFFFF);
        send_conversion(1'b0, 24'd0);

        // Random phases with fresh calibration words.
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int i = 0; i < 6; i++)
                w[i] = (ph == 5) ? 16'(i * 13107) :
                       ($urandom_range(0, 3) == 0 ? CoefW'($urandom)
                                                  : 16'($urandom_range(20000, 50000)));
            load_calibration(w);
            if (ph == 5)
                quiet_tail = 1;
            for (int n = 0; n < 310; n++)
            begin
                if (ph == 1 && n == 20)
                    hold_off = 1;
                send_conversion($urandom_range(0, 3) == 0, rand_raw());
            end
        end

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Time limit: ~1900 items, several times over.
    initial
    begin
        #40ms;
        $display("Verification failed");
        $finish;
    end
endmodule
